@@ hw/rtl/rcs_pkg.sv @@
package rcs_pkg;

   // Fixed field widths
   localparam int SEQ_W      = 31;
   localparam int WORD_W     = 32;
   localparam int LEN_W      = 14;
   localparam int PORT_W     = 16;
   localparam int BTIME_W    = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Wide enough for header + reliable + unreliable bytes before masking
   localparam int SUM_W = 18;

   localparam int MAX_PAYLOAD_DEF   = 8192;
   localparam int HEADER_BYTES      = 8;
   localparam int CLIENT_PORT_BYTES = 2;

   localparam logic [BTIME_W-1:0] BYTE_TIME_RST = 24'd10000000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IS_CLIENT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_TAG  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_TIME = 2'd2;

   // Transaction kinds
   localparam logic KIND_TX = 1'b0;
   localparam logic KIND_RX = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [WORD_W-1:0]   now_ms;
      logic [LEN_W-1:0]    pending_length;
      logic                pending_overflowed;
      logic [LEN_W-1:0]    unreliable_length;
      logic [WORD_W-1:0]   rx_sequence_word;
      logic [WORD_W-1:0]   rx_ack_word;
      logic [PORT_W-1:0]   rx_port_tag;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   header_first;
      logic [WORD_W-1:0]   header_second;
      logic                carries_reliable;
      logic [LEN_W-1:0]    reliable_bytes;
      logic                unreliable_included;
      logic [LEN_W-1:0]    packet_length;
      logic                took_message;
      logic                channel_dropped;
      logic                accepted;
      logic                can_packet;
      logic                can_reliable;
   } rsp_type;

   typedef struct packed {
      logic                    we;
      logic [CSR_IDX_W-1:0]    index;
      logic [CSR_DATA_W-1:0]   wdata;
   } csr_type;

endpackage

@@ hw/rtl/rcs_req_if.sv @@
interface rcs_req_if
   import rcs_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [WORD_W-1:0]   now_ms;
   logic [LEN_W-1:0]    pending_length;
   logic                pending_overflowed;
   logic [LEN_W-1:0]    unreliable_length;
   logic [WORD_W-1:0]   rx_sequence_word;
   logic [WORD_W-1:0]   rx_ack_word;
   logic [PORT_W-1:0]   rx_port_tag;

   modport source (
      output valid, kind, now_ms, pending_length, pending_overflowed,
             unreliable_length, rx_sequence_word, rx_ack_word, rx_port_tag,
      input  ready
   );

   modport sink (
      input  valid, kind, now_ms, pending_length, pending_overflowed,
             unreliable_length, rx_sequence_word, rx_ack_word, rx_port_tag,
      output ready
   );
endinterface

@@ hw/rtl/rcs_rsp_if.sv @@
interface rcs_rsp_if
   import rcs_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   header_first;
   logic [WORD_W-1:0]   header_second;
   logic                carries_reliable;
   logic [LEN_W-1:0]    reliable_bytes;
   logic                unreliable_included;
   logic [LEN_W-1:0]    packet_length;
   logic                took_message;
   logic                channel_dropped;
   logic                accepted;
   logic                can_packet;
   logic                can_reliable;

   modport source (
      output valid, header_first, header_second, carries_reliable, reliable_bytes,
             unreliable_included, packet_length, took_message, channel_dropped,
             accepted, can_packet, can_reliable,
      input  ready
   );

   modport sink (
      input  valid, header_first, header_second, carries_reliable, reliable_bytes,
             unreliable_included, packet_length, took_message, channel_dropped,
             accepted, can_packet, can_reliable,
      output ready
   );
endinterface

@@ hw/rtl/reliable_channel_sequencer.sv @@
// Flow: a transaction accepted on req_ch is held in the input register; its
// result is then registered in the result register and shown on rsp_ch.
// Throughput: one transaction per cycle unless rsp_ch stalls; the header
// decision runs in a single engine pass from input register to result register.
// Reset (synchronous, active high): all channel state and choke time clear,
// byte_time returns to 10000000, both channel registers empty.
module reliable_channel_sequencer
   import rcs_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   rcs_req_if.sink               req_ch,
   rcs_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Input register: holds the transaction waiting for the engine
   logic    stage_valid_ff, stage_valid_in;
   req_type stage_item_ff, stage_item_in;
   // Result register: holds the finished transaction until the sink takes it
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   logic    advance;
   logic    req_fire;
   req_type req_item;
   rsp_type engine_result;
   csr_type csr;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   // Gather the request fields into one word
   assign req_item.kind               = req_ch.kind;
   assign req_item.now_ms             = req_ch.now_ms;
   assign req_item.pending_length     = req_ch.pending_length;
   assign req_item.pending_overflowed = req_ch.pending_overflowed;
   assign req_item.unreliable_length  = req_ch.unreliable_length;
   assign req_item.rx_sequence_word   = req_ch.rx_sequence_word;
   assign req_item.rx_ack_word        = req_ch.rx_ack_word;
   assign req_item.rx_port_tag        = req_ch.rx_port_tag;

   // Advance the staged transaction whenever the result register is free or
   // being emptied this cycle; the engine commits channel state only on that edge.
   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !stage_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      stage_item_in  = stage_item_ff;
      stage_valid_in = stage_valid_ff;
      if (req_fire) begin
         stage_item_in  = req_item;
         stage_valid_in = 1'b1;
      end else if (advance) begin
         // Drop the staged transaction once it has moved on
         stage_valid_in = 1'b0;
      end
   end

   rcs_engine #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .fire   (stage_valid_ff && advance),
      .item   (stage_item_ff),
      .result (engine_result)
   );

   always_comb begin
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff;
      if (stage_valid_ff && advance) begin
         out_data_in  = engine_result;
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      stage_item_ff <= stage_item_in;
      out_data_ff   <= out_data_in;
   end

   assign rsp_ch.valid               = out_valid_ff;
   assign rsp_ch.header_first        = out_data_ff.header_first;
   assign rsp_ch.header_second       = out_data_ff.header_second;
   assign rsp_ch.carries_reliable    = out_data_ff.carries_reliable;
   assign rsp_ch.reliable_bytes      = out_data_ff.reliable_bytes;
   assign rsp_ch.unreliable_included = out_data_ff.unreliable_included;
   assign rsp_ch.packet_length       = out_data_ff.packet_length;
   assign rsp_ch.took_message        = out_data_ff.took_message;
   assign rsp_ch.channel_dropped     = out_data_ff.channel_dropped;
   assign rsp_ch.accepted            = out_data_ff.accepted;
   assign rsp_ch.can_packet          = out_data_ff.can_packet;
   assign rsp_ch.can_reliable        = out_data_ff.can_reliable;

endmodule

@@ hw/rtl/rcs_engine.sv @@
module rcs_engine
   import rcs_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    fire,
   input  req_type item,
   output rsp_type result
);

   localparam logic [SUM_W-1:0] ROOM_LIMIT = SUM_W'(MAX_PAYLOAD + HEADER_BYTES);
   localparam logic [SUM_W-1:0] MAX_SUM    = SUM_W'(MAX_PAYLOAD);
   localparam logic [LEN_W-1:0] MAX_LEN    = LEN_W'(MAX_PAYLOAD);

   // Configuration
   logic                 is_client_ff, is_client_in;
   logic [PORT_W-1:0]    port_tag_ff, port_tag_in;
   logic [BTIME_W-1:0]   byte_time_ff, byte_time_in;

   // Channel state
   logic [SEQ_W-1:0]     out_seq_ff, out_seq_in;
   logic [SEQ_W-1:0]     in_seq_ff, in_seq_in;
   logic [SEQ_W-1:0]     in_ack_ff, in_ack_in;
   logic [SEQ_W-1:0]     last_sent_ff, last_sent_in;
   logic                 acked_bit_ff, acked_bit_in;
   logic                 in_bit_ff, in_bit_in;
   logic                 out_bit_ff, out_bit_in;
   logic [LEN_W-1:0]     held_ff, held_in;
   logic                 dropped_ff, dropped_in;
   // Choke time is kept as base plus the last increment, added on use
   logic [WORD_W-1:0]    choke_base_ff, choke_base_in;
   logic [WORD_W-1:0]    choke_inc_ff, choke_inc_in;

   logic [WORD_W-1:0]    choke_now;
   logic                 can_packet;
   logic                 tx_go, rx_ok;
   logic                 resend, take, send_rel;
   logic [LEN_W-1:0]     held_take;
   logic [SEQ_W-1:0]     seq_next;
   logic [SUM_W-1:0]     cur_base, cur_total;
   logic                 fits;
   logic [SEQ_W-1:0]     rx_seq;
   logic                 rx_abit;
   logic [SUM_W+BTIME_W-1:0] product;

   always_comb begin
      is_client_in = is_client_ff;
      port_tag_in  = port_tag_ff;
      byte_time_in = byte_time_ff;
      if (csr.we) begin
         unique case (csr.index)
            CSR_IS_CLIENT: is_client_in = csr.wdata[0];
            CSR_PORT_TAG:  port_tag_in  = csr.wdata[PORT_W-1:0];
            CSR_BYTE_TIME: byte_time_in = csr.wdata[BTIME_W-1:0];
            default:       ;
         endcase
      end
   end

   assign choke_now  = choke_base_ff + choke_inc_ff;
   assign can_packet = choke_now < item.now_ms;

   // Transmit path
   assign tx_go  = (item.kind == KIND_TX) && !item.pending_overflowed;
   assign resend = (in_ack_ff > last_sent_ff) && (acked_bit_ff != out_bit_ff);
   assign take   = (held_ff == '0) && (item.pending_length != '0);
   assign held_take = ({{(SUM_W-LEN_W){1'b0}}, item.pending_length} > MAX_SUM) ?
                      MAX_LEN : item.pending_length;
   assign send_rel = resend || take;
   assign seq_next = out_seq_ff + 1'b1;

   always_comb begin
      cur_base = SUM_W'(HEADER_BYTES);
      if (is_client_ff) cur_base = cur_base + SUM_W'(CLIENT_PORT_BYTES);
      if (send_rel) begin
         cur_base = cur_base + {{(SUM_W-LEN_W){1'b0}}, (take ? held_take : held_ff)};
      end
   end

   assign fits      = (cur_base + {{(SUM_W-LEN_W){1'b0}}, item.unreliable_length})
                      <= ROOM_LIMIT;
   assign cur_total = fits ? cur_base + {{(SUM_W-LEN_W){1'b0}}, item.unreliable_length}
                           : cur_base;
   assign product   = {{BTIME_W{1'b0}}, cur_total} * {{SUM_W{1'b0}}, byte_time_ff};

   // Receive path
   assign rx_seq  = item.rx_sequence_word[SEQ_W-1:0];
   assign rx_abit = item.rx_ack_word[WORD_W-1];
   assign rx_ok   = (item.kind == KIND_RX) &&
                    (is_client_ff || (port_tag_ff == item.rx_port_tag)) &&
                    (rx_seq > in_seq_ff);

   always_comb begin
      out_seq_in    = out_seq_ff;
      in_seq_in     = in_seq_ff;
      in_ack_in     = in_ack_ff;
      last_sent_in  = last_sent_ff;
      acked_bit_in  = acked_bit_ff;
      in_bit_in     = in_bit_ff;
      out_bit_in    = out_bit_ff;
      held_in       = held_ff;
      dropped_in    = dropped_ff;
      choke_base_in = choke_base_ff;
      choke_inc_in  = choke_inc_ff;
      if (fire) begin
         if (item.kind == KIND_TX && item.pending_overflowed) begin
            dropped_in = 1'b1;
         end
         if (tx_go) begin
            if (take) begin
               held_in    = held_take;
               out_bit_in = !out_bit_ff;
            end
            out_seq_in = seq_next;
            if (send_rel) last_sent_in = seq_next;
            choke_base_in = can_packet ? item.now_ms : choke_now;
            choke_inc_in  = product[WORD_W-1:0];
         end
         if (rx_ok) begin
            if (rx_abit == out_bit_ff) held_in = '0;
            in_seq_in    = rx_seq;
            in_ack_in    = item.rx_ack_word[SEQ_W-1:0];
            acked_bit_in = rx_abit;
            in_bit_in    = in_bit_ff ^ item.rx_sequence_word[WORD_W-1];
         end
      end
   end

   always_comb begin
      result = '0;
      result.header_second   = {in_bit_in, in_seq_in};
      result.reliable_bytes  = held_in;
      result.channel_dropped = dropped_in;
      result.can_packet      = can_packet;
      result.can_reliable    = can_packet && (held_ff == '0);
      result.accepted        = rx_ok;
      if (tx_go) begin
         result.header_first        = {send_rel, out_seq_ff};
         result.carries_reliable    = send_rel;
         result.unreliable_included = fits;
         result.packet_length       = cur_total[LEN_W-1:0];
         result.took_message        = take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_client_ff  <= 1'b0;
         port_tag_ff   <= '0;
         byte_time_ff  <= BYTE_TIME_RST;
         out_seq_ff    <= '0;
         in_seq_ff     <= '0;
         in_ack_ff     <= '0;
         last_sent_ff  <= '0;
         acked_bit_ff  <= 1'b0;
         in_bit_ff     <= 1'b0;
         out_bit_ff    <= 1'b0;
         held_ff       <= '0;
         dropped_ff    <= 1'b0;
         choke_base_ff <= '0;
         choke_inc_ff  <= '0;
      end else begin
         is_client_ff  <= is_client_in;
         port_tag_ff   <= port_tag_in;
         byte_time_ff  <= byte_time_in;
         out_seq_ff    <= out_seq_in;
         in_seq_ff     <= in_seq_in;
         in_ack_ff     <= in_ack_in;
         last_sent_ff  <= last_sent_in;
         acked_bit_ff  <= acked_bit_in;
         in_bit_ff     <= in_bit_in;
         out_bit_ff    <= out_bit_in;
         held_ff       <= held_in;
         dropped_ff    <= dropped_in;
         choke_base_ff <= choke_base_in;
         choke_inc_ff  <= choke_inc_in;
      end
   end

endmodule
